### sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/eta_sq_pkg.sv
// constants, sequencer states and command bundle of the eta squared core
// no dependencies
package eta_sq_pkg;

  localparam int MAX_LEN   = 4096;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 30;
  localparam int SQ_W      = 44;
  localparam int DQ_W      = 45;
  localparam int WIDE_W    = 58;
  localparam int PROD_W    = 36;
  localparam int Q_SPLIT   = 22;
  localparam int D_SPLIT   = 23;
  localparam int A_SPLIT   = 29;
  localparam int SNUM_W    = 20;
  localparam int SCALED_W  = A_SPLIT + SNUM_W;
  localparam int NUM_W     = 78;
  localparam int DEN_W     = 65;
  localparam int ETA_W     = 14;
  localparam int DIV_CNT_W = 4;

  localparam logic [SNUM_W-1:0] SCALE_NUM = SNUM_W'(1000049);
  localparam logic [6:0]        SCALE_DEN = 7'd100;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_MUL,
    ST_COMB,
    ST_DIFF,
    ST_CHECK,
    ST_SCALE,
    ST_MERGE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic acc;
    logic mul;
    logic comb;
    logic diff;
    logic check;
    logic scale;
    logic merge;
    logic div_step;
    logic out_load;
    logic clear;
  } cmd_t;

endpackage

### sv/eta_sq_ctrl.sv
// sequencer for the eta squared core: accumulate, then the finishing steps
// depends on eta_sq_pkg
module eta_sq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last,
  input  logic              out_stall,
  input  logic              degen,
  output logic              in_stall,
  output logic              out_valid,
  output eta_sq_pkg::cmd_t  cmd
);
  import eta_sq_pkg::*;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM:  if (in_valid && last) state_next = ST_MUL;
      ST_MUL:    state_next = ST_COMB;
      ST_COMB:   state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_SCALE;
      ST_SCALE:  state_next = degen ? ST_FINISH : ST_MERGE;
      ST_MERGE:  state_next = ST_DIV;
      ST_DIV:    if (div_cnt == DIV_CNT_W'(ETA_W - 1)) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_ACCUM;
      default:   state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    div_cnt_next   = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_ACCUM: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
      end
      ST_MUL:   cmd.mul   = 1'b1;
      ST_COMB:  cmd.comb  = 1'b1;
      ST_DIFF:  cmd.diff  = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_MERGE: cmd.merge = 1'b1;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.clear      = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

### sv/eta_sq_datapath.sv
// running sums, split products, restoring divider and result register
// depends on eta_sq_pkg
module eta_sq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  eta_sq_pkg::cmd_t              cmd,
  input  logic signed [15:0]            x_sample,
  input  logic signed [15:0]            y_sample,
  output logic                          degen,
  output logic [eta_sq_pkg::ETA_W-1:0]  eta_scaled,
  output logic                          degenerate,
  output logic                          overflowed
);
  import eta_sq_pkg::*;

  logic [CNT_W-1:0]        pair_count;
  logic signed [SUM_W-1:0] sum_total;
  logic [SQ_W-1:0]         sum_squares;
  logic [DQ_W-1:0]         sum_diff_squares;
  logic                    overflow_seen;

  logic signed [16:0] pair_sum, pair_diff;
  logic signed [31:0] xx, yy;
  logic signed [33:0] dd;
  logic [31:0]        sq_pair;

  logic signed [59:0] s_sq;
  logic [CNT_W:0]     n2;
  logic [WIDE_W-1:0]  s2, q2, num2, denom2, diffa;
  logic [PROD_W-1:0]  pq_lo, pq_hi, pd_lo, pd_hi;
  logic [SCALED_W-1:0] pa_lo, pa_hi;
  logic [DEN_W-1:0]   den, rem;
  logic [NUM_W-1:0]   num_full;
  logic [ETA_W-1:0]   num_low, quo;
  logic [DEN_W+1:0]   trial;

  assign pair_sum  = 17'(x_sample) + 17'(y_sample);
  assign pair_diff = 17'(x_sample) - 17'(y_sample);
  assign xx        = 32'(x_sample) * 32'(x_sample);
  assign yy        = 32'(y_sample) * 32'(y_sample);
  assign dd        = 34'(pair_diff) * 34'(pair_diff);
  assign sq_pair   = $unsigned(xx) + $unsigned(yy);

  // accumulation
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pair_count       <= '0;
      sum_total        <= '0;
      sum_squares      <= '0;
      sum_diff_squares <= '0;
      overflow_seen    <= 1'b0;
    end else if (cmd.acc) begin
      if (pair_count == CNT_W'(MAX_LEN)) begin
        overflow_seen <= 1'b1;
      end else begin
        pair_count       <= pair_count + 1'b1;
        sum_total        <= sum_total + SUM_W'(pair_sum);
        sum_squares      <= sum_squares + SQ_W'(sq_pair);
        sum_diff_squares <= sum_diff_squares + DQ_W'($unsigned(dd));
      end
    end
  end

  assign s_sq     = 60'(sum_total) * 60'(sum_total);
  assign n2       = {pair_count, 1'b0};
  assign num_full = (NUM_W'(pa_hi) << A_SPLIT) + NUM_W'(pa_lo);
  assign trial    = {1'b0, rem, num_low[ETA_W-1]} - {2'b00, den};

  // finishing steps
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      s2    <= WIDE_W'($unsigned(s_sq));
      pq_lo <= PROD_W'(n2) * PROD_W'(sum_squares[Q_SPLIT-1:0]);
      pq_hi <= PROD_W'(n2) * PROD_W'(sum_squares[SQ_W-1:Q_SPLIT]);
      pd_lo <= PROD_W'(pair_count) * PROD_W'(sum_diff_squares[D_SPLIT-1:0]);
      pd_hi <= PROD_W'(pair_count) * PROD_W'(sum_diff_squares[DQ_W-1:D_SPLIT]);
    end
    if (cmd.comb) begin
      q2   <= (WIDE_W'(pq_hi) << Q_SPLIT) + WIDE_W'(pq_lo);
      num2 <= (WIDE_W'(pd_hi) << D_SPLIT) + WIDE_W'(pd_lo);
    end
    if (cmd.diff) begin
      denom2 <= q2 - s2;
    end
    if (cmd.check) begin
      degen <= (denom2 == '0) || (num2 >= denom2);
      diffa <= denom2 - num2;
    end
    if (cmd.scale) begin
      pa_lo <= SCALED_W'(diffa[A_SPLIT-1:0]) * SCALED_W'(SCALE_NUM);
      pa_hi <= SCALED_W'(diffa[WIDE_W-1:A_SPLIT]) * SCALED_W'(SCALE_NUM);
      den   <= DEN_W'(denom2) * DEN_W'(SCALE_DEN);
    end
    if (cmd.merge) begin
      rem     <= DEN_W'(num_full[NUM_W-1:ETA_W]);
      num_low <= num_full[ETA_W-1:0];
      quo     <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DEN_W+1]) rem <= trial[DEN_W-1:0];
      else                 rem <= {rem[DEN_W-2:0], num_low[ETA_W-1]};
      num_low <= num_low << 1;
      quo     <= {quo[ETA_W-2:0], !trial[DEN_W+1]};
    end
    if (cmd.out_load) begin
      eta_scaled <= degen ? '0 : quo;
      degenerate <= degen;
      overflowed <= overflow_seen;
    end
  end

endmodule

### sv/eta_squared_similarity_core.sv
// top level of the eta squared similarity core
// depends on eta_sq_pkg, eta_sq_ctrl, eta_sq_datapath
//
// channel  direction  signals
// input    in         in_valid, in_stall, x_sample, y_sample, last
// output   out        out_valid, out_stall, eta_scaled, degenerate, overflowed
//
// one pair per cycle while accumulating; a pair without last yields no transfer
// a pair with last starts the finish sequence: mul, comb, diff, check and scale, then finish when
//   degenerate, else a merge step and 14 divider steps first, one quotient bit per cycle
// in_stall is high through the finish sequence, also while the new result waits
//   for the output register to free up
// rst is synchronous and clears all sums, the sequencer and out_valid
module eta_squared_similarity_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            x_sample,
  input  logic signed [15:0]            y_sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eta_sq_pkg::ETA_W-1:0]  eta_scaled,
  output logic                          degenerate,
  output logic                          overflowed
);
  import eta_sq_pkg::*;

  cmd_t cmd;
  logic degen;

  eta_sq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .out_stall (out_stall),
    .degen     (degen),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  eta_sq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .degen      (degen),
    .eta_scaled (eta_scaled),
    .degenerate (degenerate),
    .overflowed (overflowed)
  );

endmodule

### sv/eta_sq_checker.sv
// port-level checks for the eta squared core, bound to the top level
// depends on eta_sq_pkg and assert_macros.svh
`include "assert_macros.svh"

module eta_sq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [eta_sq_pkg::ETA_W-1:0]  eta_scaled,
  input logic                          degenerate
);
  import eta_sq_pkg::*;

  `ASSERT_IMPLY(a_degen_zero, clk, rst, out_valid && degenerate, eta_scaled == '0)
  `ASSERT_IMPLY(a_eta_range, clk, rst, out_valid, eta_scaled <= ETA_W'(10000))
  `ASSERT_NEXT(a_last_stalls, clk, rst, in_valid && !in_stall && last, in_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

endmodule

bind eta_squared_similarity_core eta_sq_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last       (last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .eta_scaled (eta_scaled),
  .degenerate (degenerate)
);

### test/eta_squared_similarity_core_tb.sv
// self-checking testbench for eta_squared_similarity_core
// depends on eta_sq_pkg and the core; predicts each result from its own running sums
`timescale 1ns / 1ps

module eta_squared_similarity_core_tb;

  localparam int MAX_PAIRS    = eta_sq_pkg::MAX_LEN;
  localparam int RANDOM_PAIRS = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic [eta_sq_pkg::ETA_W-1:0] eta;
    logic                         degen;
    logic                         ovf;
  } eta_result_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_MATCH,
    PAT_NEAR,
    PAT_OPPOSITE,
    PAT_EXTREME,
    PAT_CONST
  } pattern_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [15:0]           x_sample = '0;
  logic signed [15:0]           y_sample = '0;
  logic                         last = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [eta_sq_pkg::ETA_W-1:0] eta_scaled;
  logic                         degenerate;
  logic                         overflowed;

  // running sums of the vector being received
  logic [63:0] sum_n;
  longint      sum_xy;
  logic [63:0] sum_sq;
  logic [63:0] sum_dsq;
  logic        sum_ovf;

  eta_result_t pending_etas[$];

  bit idling_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_count;
  int idle_count = 0;
  int errors = 0;
  int pairs_sent = 0;
  int vectors_sent = 0;
  int results_seen = 0;
  int degen_seen = 0;
  int ovf_seen = 0;

  eta_squared_similarity_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .eta_scaled (eta_scaled),
    .degenerate (degenerate),
    .overflowed (overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_sums();
    sum_n   = '0;
    sum_xy  = 0;
    sum_sq  = '0;
    sum_dsq = '0;
    sum_ovf = 1'b0;
  endfunction

  function automatic eta_result_t close_vector();
    eta_result_t  res;
    logic [63:0]  mag;
    logic [127:0] s2;
    logic [127:0] den2;
    logic [127:0] num2;
    logic [127:0] quot;
    mag  = (sum_xy < 0) ? 64'(-sum_xy) : 64'(sum_xy);
    s2   = {64'd0, mag} * {64'd0, mag};
    den2 = ({64'd0, sum_n} << 1) * {64'd0, sum_sq} - s2;
    num2 = {64'd0, sum_n} * {64'd0, sum_dsq};
    res.degen = (den2 == '0) || (num2 >= den2);
    res.ovf   = sum_ovf;
    res.eta   = '0;
    if (!res.degen) begin
      quot    = ((den2 - num2) * 128'd1000049) / (den2 * 128'd100);
      res.eta = quot[eta_sq_pkg::ETA_W-1:0];
    end
    clear_sums();
    return res;
  endfunction

  function automatic void fold_pair(logic signed [15:0] xs, logic signed [15:0] ys, logic lst);
    longint xl;
    longint yl;
    xl = xs;
    yl = ys;
    if (sum_n >= 64'(MAX_PAIRS)) begin
      sum_ovf = 1'b1;
    end else begin
      sum_n   = sum_n + 64'd1;
      sum_xy  = sum_xy + xl + yl;
      sum_sq  = sum_sq + 64'(xl * xl + yl * yl);
      sum_dsq = sum_dsq + 64'((xl - yl) * (xl - yl));
    end
    if (lst) begin
      pending_etas.push_back(close_vector());
      vectors_sent++;
    end
  endfunction

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    x_sample <= 16'($urandom);
    y_sample <= 16'($urandom);
    last     <= 1'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // offer one pair and hold it until the transfer
  task automatic send_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                           input logic lst);
    in_valid <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    last     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_pair(xs, ys, lst);
    pairs_sent++;
    if (idling_on && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 4));
  endtask

  function automatic logic signed [15:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic send_vector(input int len, input pattern_t pat);
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] base;
    int i;
    base = 16'($urandom);
    for (i = 0; i < len; i++) begin
      xs = 16'($urandom);
      ys = 16'($urandom);
      case (pat)
        PAT_MATCH:    ys = xs;
        PAT_NEAR:     ys = xs + 16'($signed($urandom_range(0, 64)) - 32);
        PAT_OPPOSITE: ys = -xs;
        PAT_EXTREME: begin
          xs = extreme_value();
          ys = extreme_value();
        end
        PAT_CONST: begin
          xs = base;
          ys = base + 16'(i % 2);
        end
        default: ;
      endcase
      send_pair(xs, ys, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // one pair is always degenerate
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    // full match gives the top score
    send_pair(16'sd100, 16'sd100, 1'b0);
    send_pair(-16'sd200, -16'sd200, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    // opposite vectors
    send_pair(16'sd1000, -16'sd1000, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd5, -16'sd5, 1'b1);
    // extremes of both fields
    send_pair(-16'sd32768, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    // partial similarity
    send_pair(16'sd10, 16'sd12, 1'b0);
    send_pair(16'sd20, 16'sd18, 1'b0);
    send_pair(-16'sd30, -16'sd25, 1'b0);
    send_pair(16'sd0, 16'sd3, 1'b1);
  endtask

  // one vector past full, last on an ignored pair
  task automatic test_overflow();
    int i;
    for (i = 0; i < MAX_PAIRS + 2; i++) begin
      send_pair(extreme_value(), extreme_value(), i == MAX_PAIRS + 1);
    end
  endtask

  task automatic test_random();
    int start;
    int len;
    start = pairs_sent;
    while (pairs_sent - start < RANDOM_PAIRS) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      send_vector(len, pattern_t'($urandom_range(0, 5)));
    end
  endtask

  // receiver holds off while short vectors keep coming
  task automatic test_pressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 20; i++) send_vector($urandom_range(1, 3), pattern_t'($urandom_range(0, 5)));
  endtask

  task automatic test_steady();
    int i;
    idling_on = 1'b0;
    for (i = 0; i < 40; i++) send_vector($urandom_range(1, 8), pattern_t'($urandom_range(0, 5)));
  endtask

  initial begin
    clear_sums();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random();
    test_pressure();
    test_steady();
    in_valid <= 1'b0;
    while (pending_etas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pairs in %0d vectors, %0d results checked", pairs_sent, vectors_sent,
             results_seen);
    $display("%0d degenerate and %0d overflowed results seen", degen_seen, ovf_seen);
    if (errors == 0) begin
      $display("eta_squared_similarity_core_tb: clean");
    end else begin
      $display("eta_squared_similarity_core_tb: errors");
    end
    $finish;
  end

  // result side stall, random bursts and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0d got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    eta_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      degen_seen += degenerate;
      ovf_seen += overflowed;
      if (pending_etas.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result transfer with nothing expected");
      end else begin
        want = pending_etas.pop_front();
        check_field("eta_scaled", want.eta, eta_scaled);
        check_field("degenerate", want.degen, degenerate);
        check_field("overflowed", want.ovf, overflowed);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding", idle_count,
                 pending_etas.size());
        $display("eta_squared_similarity_core_tb: errors");
        $finish;
      end
    end
  end

endmodule
